// ----- src/fol_pkg.sv -----
// ----------------------------------------------------------------------------
// fol_pkg
// Shared constants, codes and types for the frequency ordered list locate unit.
// ----------------------------------------------------------------------------
package fol_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OPOS_W   = 4;
    localparam int OCNT_W   = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // cell update operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_BUMP   = 2'd2;
    localparam logic [1:0] OP_MOVE   = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [LEN_W-1:0]       len_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [1:0]              op;
        len_t                    used;
        logic signed [KEY_W-1:0] key;
        count_t                  count;
        pos_t                    found;
        pos_t                    dest;
    } bcast_t;

    function automatic logic [OPOS_W-1:0] to_out_pos(input pos_t p);
        logic [31:0] t;
        t = 32'(p);
        return t[OPOS_W-1:0];
    endfunction

    function automatic logic [OCNT_W-1:0] to_out_count(input count_t c);
        logic [31:0] t;
        t = 32'(c);
        return t[OCNT_W-1:0];
    endfunction

endpackage

// ----- src/fol_cmd_if.sv -----
// ----------------------------------------------------------------------------
// fol_cmd_if
// Command channel: valid/ready with command, key and index payload.
// ----------------------------------------------------------------------------
interface fol_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [fol_pkg::CMD_W-1:0]           command;
    logic signed [fol_pkg::KEY_W-1:0]    key;
    logic [fol_pkg::IDX_W-1:0]           index;

    modport source (output valid, command, key, index, input ready);
    modport sink   (input valid, command, key, index, output ready);
endinterface

// ----- src/fol_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fol_rsp_if
// Response channel: valid/ready with status, positions and entry payload.
// ----------------------------------------------------------------------------
interface fol_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [fol_pkg::STATUS_W-1:0]        status;
    logic [fol_pkg::OPOS_W-1:0]          old_position;
    logic [fol_pkg::OPOS_W-1:0]          new_position;
    logic signed [fol_pkg::KEY_W-1:0]    entry_key;
    logic [fol_pkg::OCNT_W-1:0]          entry_count;

    modport source (output valid, status, old_position, new_position, entry_key,
                    entry_count, input ready);
    modport sink   (input valid, status, old_position, new_position, entry_key,
                    entry_count, output ready);
endinterface

// ----- src/fol_cell.sv -----
// ----------------------------------------------------------------------------
// fol_cell
// One table entry: compares against the broadcast key and takes data from
// its neighbors when an entry moves through the row.
// ----------------------------------------------------------------------------
module fol_cell (
    input  logic                             clk,
    input  fol_pkg::pos_t                    pos,
    input  fol_pkg::bcast_t                  bc,
    input  logic signed [fol_pkg::KEY_W-1:0] prev_key,
    input  fol_pkg::count_t                  prev_count,
    input  logic signed [fol_pkg::KEY_W-1:0] next_key,
    input  fol_pkg::count_t                  next_count,
    output logic signed [fol_pkg::KEY_W-1:0] key,
    output fol_pkg::count_t                  count,
    output logic                             match,
    output logic                             le
);

    logic signed [fol_pkg::KEY_W-1:0] key_reg, key_next;
    fol_pkg::count_t                  count_reg, count_next;
    logic                             in_use;

    assign in_use = fol_pkg::len_t'(pos) < bc.used;
    assign match  = in_use && (key_reg == bc.key);
    assign le     = in_use && (pos != bc.found) && (count_reg <= bc.count);
    assign key    = key_reg;
    assign count  = count_reg;

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        unique case (bc.op)
            fol_pkg::OP_APPEND:
            begin
                if (fol_pkg::len_t'(pos) == bc.used)
                begin
                    key_next   = bc.key;
                    count_next = '0;
                end
            end
            fol_pkg::OP_BUMP:
            begin
                if (pos == bc.found)
                    count_next = bc.count;
            end
            fol_pkg::OP_MOVE:
            begin
                if (pos == bc.dest)
                begin
                    key_next   = bc.key;
                    count_next = bc.count;
                end
                else if (bc.dest < bc.found)
                begin
                    // entries between dest and found slide one toward the tail
                    if (pos > bc.dest && pos <= bc.found)
                    begin
                        key_next   = prev_key;
                        count_next = prev_count;
                    end
                end
                else if (pos >= bc.found && pos < bc.dest)
                begin
                    key_next   = next_key;
                    count_next = next_count;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

endmodule

// ----- src/frequency_ordered_list_locate_unit.sv -----
// ----------------------------------------------------------------------------
// frequency_ordered_list_locate_unit
// Frequency-count self-organizing list held in a row of cells.
// ----------------------------------------------------------------------------
// Results: append, read, locate miss and locate hit at the front give their
//   result in the output register in the cycle after the command transfer; a
//   locate that reorders goes through the move step first and registers it there.
// Throughput: one command per cycle while the response side is not stalled; no
//   new command is taken during the move step that shifts entries along the cell row.
// Reset clears the used length, the state and the output valid; entry
//   contents are undefined until appended.
// ----------------------------------------------------------------------------
module frequency_ordered_list_locate_unit (
    input  logic         clk,
    input  logic         rst_n,
    fol_cmd_if.sink      request,
    fol_rsp_if.source    response
);

    localparam int DEPTH = fol_pkg::TABLE_DEPTH;

    // two-step sequencer: compare step, then the move step for reordering
    localparam logic S_IDLE = 1'b0;
    localparam logic S_MOVE = 1'b1;

    logic state_reg, state_next;

    fol_pkg::len_t                    used_reg, used_next;
    fol_pkg::pos_t                    found_reg, found_next;
    fol_pkg::count_t                  cnt_reg, cnt_next;
    logic signed [fol_pkg::KEY_W-1:0] key_reg, key_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [fol_pkg::STATUS_W-1:0]        st_reg, st_next;
    logic [fol_pkg::OPOS_W-1:0]          opos_reg, opos_next;
    logic [fol_pkg::OPOS_W-1:0]          npos_reg, npos_next;
    logic signed [fol_pkg::KEY_W-1:0]    okey_reg, okey_next;
    logic [fol_pkg::OCNT_W-1:0]          ocnt_reg, ocnt_next;

    // cell row
    fol_pkg::bcast_t                  bc;
    logic signed [fol_pkg::KEY_W-1:0] cell_key   [DEPTH];
    fol_pkg::count_t                  cell_count [DEPTH];
    logic [DEPTH-1:0]                 cell_match;
    logic [DEPTH-1:0]                 cell_le;

    logic                             slot_free;
    logic                             req_xfer;
    logic                             full;
    logic                             any_match;
    fol_pkg::pos_t                    found_pos;
    fol_pkg::count_t                  found_count;
    fol_pkg::count_t                  bumped;
    logic                             idx_ok;
    logic signed [fol_pkg::KEY_W-1:0] rd_key;
    fol_pkg::count_t                  rd_count;
    logic                             le_hit;
    fol_pkg::pos_t                    le_pos;
    fol_pkg::pos_t                    dest;

    function automatic logic [fol_pkg::OPOS_W-1:0] to_pos(input fol_pkg::len_t l);
        logic [31:0] t;
        t = 32'(l);
        return t[fol_pkg::OPOS_W-1:0];
    endfunction

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            fol_cell u_cell (
                .clk        (clk),
                .pos        (fol_pkg::pos_t'(g)),
                .bc         (bc),
                .prev_key   (cell_key[(g == 0) ? 0 : g - 1]),
                .prev_count (cell_count[(g == 0) ? 0 : g - 1]),
                .next_key   (cell_key[(g == DEPTH - 1) ? g : g + 1]),
                .next_count (cell_count[(g == DEPTH - 1) ? g : g + 1]),
                .key        (cell_key[g]),
                .count      (cell_count[g]),
                .match      (cell_match[g]),
                .le         (cell_le[g])
            );
        end
    endgenerate

    assign slot_free     = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == S_IDLE) && slot_free;
    assign req_xfer      = request.valid && request.ready;
    assign full          = used_reg == fol_pkg::len_t'(DEPTH);
    assign any_match     = |cell_match;
    assign idx_ok        = 32'(request.index) < 32'(used_reg);

    // first matching cell from the front, and its count
    always_comb
    begin
        found_pos   = '0;
        found_count = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i])
                found_pos = fol_pkg::pos_t'(i);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (fol_pkg::pos_t'(i) == found_pos)
                found_count = cell_count[i];
        end
    end

    // saturating count raise
    assign bumped = (found_count == '1) ? found_count : found_count + 1'b1;

    // entry select for a read
    always_comb
    begin
        rd_key   = '0;
        rd_count = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(i) == 32'(request.index))
            begin
                rd_key   = cell_key[i];
                rd_count = cell_count[i];
            end
        end
    end

    // destination: first other entry whose count is not greater, renumbered
    // with the found slot taken out; tail when there is none
    always_comb
    begin
        le_hit = |cell_le;
        le_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_le[i])
                le_pos = fol_pkg::pos_t'(i);
        end
        if (!le_hit)
            dest = fol_pkg::pos_t'(used_reg - fol_pkg::len_t'(1));
        else if (le_pos < found_reg)
            dest = le_pos;
        else
            dest = le_pos - 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !response.ready;
        st_next        = st_reg;
        opos_next      = opos_reg;
        npos_next      = npos_reg;
        okey_next      = okey_reg;
        ocnt_next      = ocnt_reg;

        bc.op    = fol_pkg::OP_HOLD;
        bc.used  = used_reg;
        bc.key   = request.key;
        bc.count = bumped;
        bc.found = found_pos;
        bc.dest  = dest;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    out_valid_next = 1'b1;
                    st_next        = fol_pkg::ST_OK;
                    opos_next      = '0;
                    npos_next      = '0;
                    okey_next      = '0;
                    ocnt_next      = '0;
                    unique case (request.command)
                        fol_pkg::CMD_APPEND:
                        begin
                            if (full)
                                st_next = fol_pkg::ST_FULL;
                            else
                            begin
                                bc.op     = fol_pkg::OP_APPEND;
                                used_next = used_reg + 1'b1;
                                opos_next = to_pos(used_reg);
                                npos_next = to_pos(used_reg);
                                okey_next = request.key;
                            end
                        end
                        fol_pkg::CMD_LOCATE:
                        begin
                            if (!any_match)
                                st_next = fol_pkg::ST_NOT_FOUND;
                            else if (found_pos == '0)
                            begin
                                // front entry: raise count in place
                                bc.op     = fol_pkg::OP_BUMP;
                                okey_next = request.key;
                                ocnt_next = fol_pkg::to_out_count(bumped);
                            end
                            else
                            begin
                                // result comes after the move step
                                out_valid_next = 1'b0;
                                state_next     = S_MOVE;
                                found_next     = found_pos;
                                cnt_next       = bumped;
                                key_next       = request.key;
                            end
                        end
                        fol_pkg::CMD_READ:
                        begin
                            if (!idx_ok)
                                st_next = fol_pkg::ST_BAD_INDEX;
                            else
                            begin
                                opos_next = request.index;
                                npos_next = request.index;
                                okey_next = rd_key;
                                ocnt_next = fol_pkg::to_out_count(rd_count);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                bc.key   = key_reg;
                bc.count = cnt_reg;
                bc.found = found_reg;
                if (slot_free)
                begin
                    bc.op          = fol_pkg::OP_MOVE;
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    st_next        = fol_pkg::ST_OK;
                    opos_next      = fol_pkg::to_out_pos(found_reg);
                    npos_next      = fol_pkg::to_out_pos(dest);
                    okey_next      = key_reg;
                    ocnt_next      = fol_pkg::to_out_count(cnt_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
        key_reg   <= key_next;
        st_reg    <= st_next;
        opos_reg  <= opos_next;
        npos_reg  <= npos_next;
        okey_reg  <= okey_next;
        ocnt_reg  <= ocnt_next;
    end

    assign response.valid        = out_valid_reg;
    assign response.status       = st_reg;
    assign response.old_position = opos_reg;
    assign response.new_position = npos_reg;
    assign response.entry_key    = okey_reg;
    assign response.entry_count  = ocnt_reg;

    // a move step always concerns an entry behind the front
    a_move_not_front: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (found_reg != '0))
        else $error("move step with found entry at the front");

    // the table never holds more entries than cells
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= DEPTH)
        else $error("used length beyond table depth");

    // used length only grows, and only by an append transfer
    a_used_append: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            ($past(req_xfer) && ($past(request.command) == fol_pkg::CMD_APPEND)))
        else $error("used length changed without an append");

    // a locate that enters the move step holds its result until that step ends
    a_move_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE && slot_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("move step did not deliver its result");

endmodule

// ----- test/tb_frequency_ordered_list_locate_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_ordered_list_locate_unit
// Self-checking bench for the frequency ordered list: drives append, locate,
// read and unused commands and keeps a shadow copy of the table. It checks
// every response field against that copy. A short table of directed commands
// comes first, then random traffic that fills the table and keeps reordering
// it.
// ----------------------------------------------------------------------------
module tb_frequency_ordered_list_locate_unit;

    localparam int CMD_W       = fol_pkg::CMD_W;
    localparam int KEY_W       = fol_pkg::KEY_W;
    localparam int IDX_W       = fol_pkg::IDX_W;
    localparam int STATUS_W    = fol_pkg::STATUS_W;
    localparam int OPOS_W      = fol_pkg::OPOS_W;
    localparam int OCNT_W      = fol_pkg::OCNT_W;
    localparam int TABLE_DEPTH = fol_pkg::TABLE_DEPTH;
    localparam int COUNT_WIDTH = fol_pkg::COUNT_WIDTH;

    localparam logic [CMD_W-1:0] CMD_APPEND = fol_pkg::CMD_APPEND;
    localparam logic [CMD_W-1:0] CMD_LOCATE = fol_pkg::CMD_LOCATE;
    localparam logic [CMD_W-1:0] CMD_READ   = fol_pkg::CMD_READ;

    localparam logic [STATUS_W-1:0] ST_OK        = fol_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = fol_pkg::ST_NOT_FOUND;
    localparam logic [STATUS_W-1:0] ST_FULL      = fol_pkg::ST_FULL;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = fol_pkg::ST_BAD_INDEX;

    typedef fol_pkg::count_t count_t;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1820;
    localparam int POST_ITEMS    = 60;
    localparam int DRAIN_CYCLES  = 4;

    // the package leaves the fourth command code unnamed; the block answers it
    // with an all-zero OK response
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ZERO = 32'sh0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_ONES = 32'shFFFF_FFFF;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        index;
    } list_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [OPOS_W-1:0]       old_position;
        logic [OPOS_W-1:0]       new_position;
        logic signed [KEY_W-1:0] entry_key;
        logic [OCNT_W-1:0]       entry_count;
    } list_rsp_t;

    // fixed_rsp set: compare against the response typed into the row,
    // otherwise against the shadow table
    typedef struct packed {
        list_cmd_t cmd;
        logic      fixed_rsp;
        list_rsp_t rsp;
    } directed_row_t;

    localparam list_rsp_t RSP_NONE      = '0;
    localparam list_rsp_t RSP_NOT_FOUND = '{ST_NOT_FOUND, 4'd0, 4'd0, 32'sd0, 16'd0};
    localparam list_rsp_t RSP_BAD_INDEX = '{ST_BAD_INDEX, 4'd0, 4'd0, 32'sd0, 16'd0};

    // Walk-through of the table contents (key:count, front first):
    //   four appends           -> MIN:0 MAX:0 ZERO:0 ONES:0
    //   locate MIN (front)     -> MIN:1 ...
    //   locate ONES, ZERO      -> each jumps ahead of the equal count at front
    //   locate ZERO, ONES, MIN -> every count but MAX becomes 2
    //   locate MAX             -> nothing smaller, stays at the tail
    localparam directed_row_t DIRECTED_ROWS [21] = '{
        '{'{CMD_READ,   KEY_ZERO, 4'd0},  1'b1, RSP_BAD_INDEX},
        '{'{CMD_READ,   KEY_ZERO, 4'd15}, 1'b1, RSP_BAD_INDEX},
        '{'{CMD_LOCATE, KEY_ZERO, 4'd0},  1'b1, RSP_NOT_FOUND},
        '{'{CMD_UNUSED, KEY_ONES, 4'd15}, 1'b1, RSP_NONE},
        '{'{CMD_APPEND, KEY_MIN,  4'd0},  1'b1, '{ST_OK, 4'd0, 4'd0, KEY_MIN,  16'd0}},
        '{'{CMD_APPEND, KEY_MAX,  4'd0},  1'b1, '{ST_OK, 4'd1, 4'd1, KEY_MAX,  16'd0}},
        '{'{CMD_APPEND, KEY_ZERO, 4'd0},  1'b1, '{ST_OK, 4'd2, 4'd2, KEY_ZERO, 16'd0}},
        '{'{CMD_APPEND, KEY_ONES, 4'd0},  1'b1, '{ST_OK, 4'd3, 4'd3, KEY_ONES, 16'd0}},
        '{'{CMD_LOCATE, KEY_MIN,  4'd0},  1'b1, '{ST_OK, 4'd0, 4'd0, KEY_MIN,  16'd1}},
        '{'{CMD_LOCATE, KEY_ONES, 4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, KEY_ZERO, 4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, KEY_ZERO, 4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, KEY_ONES, 4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, KEY_MIN,  4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, KEY_MAX,  4'd0},  1'b0, RSP_NONE},
        '{'{CMD_LOCATE, 32'sh1234_5678, 4'd0}, 1'b1, RSP_NOT_FOUND},
        '{'{CMD_LOCATE, 32'sh7FFF_FFFE, 4'd0}, 1'b1, RSP_NOT_FOUND},
        '{'{CMD_READ,   KEY_ZERO, 4'd3},  1'b0, RSP_NONE},
        '{'{CMD_READ,   KEY_ONES, 4'd4},  1'b1, RSP_BAD_INDEX},
        // duplicate key: locate must hit the first copy, not this one
        '{'{CMD_APPEND, KEY_MIN,  4'd0},  1'b1, '{ST_OK, 4'd4, 4'd4, KEY_MIN,  16'd0}},
        '{'{CMD_LOCATE, KEY_MIN,  4'd0},  1'b0, RSP_NONE}
    };

    logic clk;
    logic rst_n;

    fol_cmd_if request_bus ();
    fol_rsp_if response_bus ();

    frequency_ordered_list_locate_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .response (response_bus)
    );

    // shadow of the table inside the block
    logic signed [KEY_W-1:0] list_keys   [TABLE_DEPTH];
    count_t                  list_counts [TABLE_DEPTH];
    int                      list_used;

    list_rsp_t pending_responses [$];
    int        mismatches;
    int        burst_left;
    int        ready_mode;
    int        ready_left;

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow table update. Applies one command and returns the response the
    // block must give for it. Locate takes the entry out and puts it back in
    // front of the first remaining entry whose count is not greater (ties go
    // behind the moved entry), or at the tail when every other count is larger.
    // ------------------------------------------------------------------------
    function automatic list_rsp_t apply_list_command(input list_cmd_t cmd);
        list_rsp_t r;
        int        found;
        int        dest;
        int        src;
        count_t    cnt;
        r = '0;
        case (cmd.command)
            CMD_APPEND:
            begin
                if (list_used >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_keys[list_used]   = cmd.key;
                    list_counts[list_used] = '0;
                    r.status       = ST_OK;
                    r.old_position = list_used[OPOS_W-1:0];
                    r.new_position = list_used[OPOS_W-1:0];
                    r.entry_key    = cmd.key;
                    list_used++;
                end
            end
            CMD_LOCATE:
            begin
                found = -1;
                for (int i = 0; i < list_used; i++)
                    if (found < 0 && list_keys[i] == cmd.key)
                        found = i;
                if (found < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    cnt = list_counts[found];
                    if (cnt != {COUNT_WIDTH{1'b1}})
                        cnt = cnt + 1'b1;
                    list_counts[found] = cnt;
                    dest = list_used - 1;
                    if (found == 0)
                        dest = 0;
                    else
                    begin
                        // remaining positions skip the slot of the entry taken out
                        for (int j = list_used - 2; j >= 0; j--)
                        begin
                            src = (j < found) ? j : j + 1;
                            if (list_counts[src] <= cnt)
                                dest = j;
                        end
                        if (dest < found)
                            for (int i = found; i > dest; i--)
                            begin
                                list_keys[i]   = list_keys[i-1];
                                list_counts[i] = list_counts[i-1];
                            end
                        else
                            for (int i = found; i < dest; i++)
                            begin
                                list_keys[i]   = list_keys[i+1];
                                list_counts[i] = list_counts[i+1];
                            end
                        list_keys[dest]   = cmd.key;
                        list_counts[dest] = cnt;
                    end
                    r.status       = ST_OK;
                    r.old_position = found[OPOS_W-1:0];
                    r.new_position = dest[OPOS_W-1:0];
                    r.entry_key    = cmd.key;
                    r.entry_count  = cnt;
                end
            end
            CMD_READ:
            begin
                if (int'(cmd.index) >= list_used)
                begin
                    r.status = ST_BAD_INDEX;
                end
                else
                begin
                    r.status       = ST_OK;
                    r.old_position = cmd.index;
                    r.new_position = cmd.index;
                    r.entry_key    = list_keys[cmd.index];
                    r.entry_count  = list_counts[cmd.index];
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random command mix. While the table has room, appends are frequent so it
    // fills early; after that they are rare and only probe the full case.
    // Most locates hit a stored key so the reordering logic stays busy; misses
    // are either random keys or a stored key with one bit flipped.
    // ------------------------------------------------------------------------
    function automatic list_cmd_t random_list_command();
        list_cmd_t cmd;
        int        pick;
        logic signed [KEY_W-1:0] stored;
        pick      = $urandom_range(0, 99);
        cmd.key   = $urandom;
        cmd.index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        stored    = (list_used > 0) ? list_keys[$urandom_range(0, list_used - 1)] : cmd.key;
        if (pick < ((list_used < TABLE_DEPTH) ? 20 : 3))
        begin
            cmd.command = CMD_APPEND;
            if ($urandom_range(0, 3) == 0)
                cmd.key = stored;
        end
        else if (pick < 75)
        begin
            cmd.command = CMD_LOCATE;
            case ($urandom_range(0, 9))
                0:       cmd.key = cmd.key;
                1:       cmd.key = stored ^ (32'sd1 << $urandom_range(0, KEY_W - 1));
                default: cmd.key = stored;
            endcase
        end
        else if (pick < 95)
        begin
            cmd.command = CMD_READ;
        end
        else
        begin
            cmd.command = CMD_UNUSED;
        end
        return cmd;
    endfunction

    // Sender pacing: bursts of random length separated by random gaps; now and
    // then a long burst so back-to-back transfers get exercised too.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            @(negedge clk);
            request_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Put one command on the request channel, hold it until the transfer, then
    // record the expected response. valid stays high afterwards so the next
    // command can follow in the very next cycle.
    task automatic send_list_command(input list_cmd_t cmd, input logic fixed_rsp,
                                     input list_rsp_t rsp);
        list_rsp_t predicted;
        pace_sender();
        @(negedge clk);
        request_bus.valid   = 1'b1;
        request_bus.command = cmd.command;
        request_bus.key     = cmd.key;
        request_bus.index   = cmd.index;
        @(posedge clk);
        while (request_bus.ready !== 1'b1)
            @(posedge clk);
        predicted = apply_list_command(cmd);
        pending_responses.push_back(fixed_rsp ? rsp : predicted);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: ready follows a mode picked for a random stretch of cycles:
    // always ready, mostly ready, coin flip, mostly stalled, or a fixed 2-of-3.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 4);
            ready_left = $urandom_range(16, 160);
        end
        ready_left--;
        case (ready_mode)
            0:       response_bus.ready = 1'b1;
            1:       response_bus.ready = ($urandom_range(0, 3) != 0);
            2:       response_bus.ready = ($urandom_range(0, 1) != 0);
            3:       response_bus.ready = ($urandom_range(0, 3) == 0);
            default: response_bus.ready = (ready_left % 3 != 0);
        endcase
    end

    // Response checker: every response transfer is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : response_check
        list_rsp_t want;
        if (rst_n && response_bus.valid === 1'b1 && response_bus.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: response expected none actual status %0h key %0h",
                         $time, response_bus.status, response_bus.entry_key);
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("status", 32'(want.status), 32'(response_bus.status));
                check_field("old_position", 32'(want.old_position),
                            32'(response_bus.old_position));
                check_field("new_position", 32'(want.new_position),
                            32'(response_bus.new_position));
                check_field("entry_key", 32'(want.entry_key),
                            32'(response_bus.entry_key));
                check_field("entry_count", 32'(want.entry_count),
                            32'(response_bus.entry_count));
            end
        end
    end

    // Watchdog, well above the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb_frequency_ordered_list_locate_unit NOT OK");
        $finish;
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        request_bus.valid    = 1'b0;
        request_bus.command  = CMD_APPEND;
        request_bus.key      = '0;
        request_bus.index    = '0;
        response_bus.ready   = 1'b0;
        list_used            = 0;
        mismatches           = 0;
        burst_left           = 0;
        ready_mode           = 0;
        ready_left           = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            list_keys[i]   = '0;
            list_counts[i] = '0;
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed commands: empty table, extreme keys, misses, bad indexes, unused code, duplicate key
        foreach (DIRECTED_ROWS[r])
            send_list_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].fixed_rsp,
                              DIRECTED_ROWS[r].rsp);

        // random traffic; fills the table, then keeps reordering it
        repeat (RANDOM_ITEMS)
            send_list_command(random_list_command(), 1'b0, RSP_NONE);

        // a few more mixed commands against a long-lived table
        repeat (POST_ITEMS)
            send_list_command(random_list_command(), 1'b0, RSP_NONE);

        @(negedge clk);
        request_bus.valid = 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_frequency_ordered_list_locate_unit OK");
        else
            $display("tb_frequency_ordered_list_locate_unit NOT OK");
        $finish;
    end

endmodule
